// File: sv/moesi_pkg.sv
package moesi_pkg;

    localparam int LINES_DEF     = 1024;
    localparam int ADDR_BITS_DEF = 48;

    localparam int FIELD_ADDR_W = 48;
    localparam int FIELD_IDX_W  = 10;

    typedef enum logic [3:0] {
        ST_I  = 4'd0,
        ST_IS = 4'd1,
        ST_IE = 4'd2,
        ST_S  = 4'd3,
        ST_E  = 4'd4,
        ST_EI = 4'd5,
        ST_M  = 4'd6,
        ST_MI = 4'd7,
        ST_O  = 4'd8,
        ST_OE = 4'd9
    } line_state_t;

    typedef struct packed {
        line_state_t state;
        logic [1:0]  opcode;
        logic [1:0]  requester;
    } line_entry_t;

    localparam logic [1:0] KIND_L1_REQ  = 2'd0;
    localparam logic [1:0] KIND_CC_RESP = 2'd1;
    localparam logic [1:0] KIND_SNOOP   = 2'd2;
    localparam logic [1:0] KIND_SET_MOD = 2'd3;

    localparam logic [1:0] OP_GETS = 2'd0;
    localparam logic [1:0] OP_GETE = 2'd1;
    localparam logic [1:0] OP_PUT  = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [2:0] SNP_READ_SHARED  = 3'd0;
    localparam logic [2:0] SNP_READ_UNIQUE  = 3'd1;
    localparam logic [2:0] SNP_MAKE_INVALID = 3'd2;
    localparam logic [2:0] SNP_CLEAN_INVAL  = 3'd3;

    localparam logic [2:0] CMD_NONE         = 3'd0;
    localparam logic [2:0] CMD_READ_SHARED  = 3'd1;
    localparam logic [2:0] CMD_READ_UNIQUE  = 3'd2;
    localparam logic [2:0] CMD_CLEAN_UNIQUE = 3'd3;
    localparam logic [2:0] CMD_EVICT        = 3'd4;
    localparam logic [2:0] CMD_WRITE_BACK   = 3'd5;

    localparam logic [1:0] RSP_NONE       = 2'd0;
    localparam logic [1:0] RSP_NOT_SHARED = 2'd1;
    localparam logic [1:0] RSP_SHARED     = 2'd2;

    localparam logic [2:0] BC_NONE         = 3'd0;
    localparam logic [2:0] BC_INVAL_OTHERS = 3'd1;
    localparam logic [2:0] BC_SHARE_OTHERS = 3'd2;
    localparam logic [2:0] BC_INVAL_ALL    = 3'd3;
    localparam logic [2:0] BC_SHARE_ALL    = 3'd4;

    localparam logic [1:0] TR_NONE  = 2'd0;
    localparam logic [1:0] TR_START = 2'd1;
    localparam logic [1:0] TR_END   = 2'd2;

    localparam logic [1:0] STAT_CONSUMED = 2'd0;
    localparam logic [1:0] STAT_IGNORED  = 2'd1;
    localparam logic [1:0] STAT_FATAL    = 2'd2;

    // bit3 data transfer, bit2 pass dirty, bit1 is shared, bit0 was unique
    localparam logic [3:0] SF_NONE       = 4'h0;
    localparam logic [3:0] SF_SHARED_FWD = 4'hB;
    localparam logic [3:0] SF_SHARED     = 4'hA;
    localparam logic [3:0] SF_UNIQUE     = 4'h9;
    localparam logic [3:0] SF_UNIQUE_DRT = 4'hD;
    localparam logic [3:0] SF_CLEAN_DRT  = 4'hC;

endpackage

// File: sv/moesi_ram.sv
module moesi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/moesi_l2_line_coherence_unit.sv
// the result of an accepted event is registered in the s1 stage and then in the output registers
// throughput: one event per cycle while busy is low, any line order; results cannot be held off
// line table is one ram with a registered read port; the write of the previous
// event is forwarded when the next event hits the same line
// reset: busy stays high while every line is cleared to invalid
module moesi_l2_line_coherence_unit #(
    parameter int LINES     = moesi_pkg::LINES_DEF,
    parameter int ADDR_BITS = moesi_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [9:0]  line_index,
    input  logic [47:0] line_addr,
    input  logic [1:0]  requester,
    input  logic [1:0]  l1_opcode,
    input  logic [2:0]  snoop_opcode,
    input  logic        resp_shared,
    input  logic        resp_dirty,
    input  logic        evicted,
    output logic        done,
    output logic [3:0]  new_state,
    output logic [2:0]  cc_command,
    output logic [1:0]  l1_response,
    output logic [1:0]  l1_target,
    output logic        snoop_resp_valid,
    output logic [3:0]  snoop_resp_flags,
    output logic [2:0]  l1_broadcast,
    output logic [1:0]  transaction,
    output logic        remove_line,
    output logic [1:0]  status,
    output logic [47:0] out_addr
);

    localparam int IDX_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int ENTRY_W = $bits(moesi_pkg::line_entry_t);
    localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(LINES - 1);
    localparam logic [47:0] ADDR_MASK =
        (ADDR_BITS >= 48) ? {48{1'b1}} : 48'((64'd1 << ADDR_BITS) - 64'd1);

    logic                  accept;
    logic [9:0]            slot_rem;
    logic [IDX_W-1:0]      idx_in;

    logic                  clear_reg;
    logic [IDX_W-1:0]      clr_cnt_reg;

    logic                  s1_valid_reg;
    logic [1:0]            s1_kind_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic [47:0]           s1_addr_reg;
    logic [1:0]            s1_req_reg;
    logic [1:0]            s1_op_reg;
    logic [2:0]            s1_snp_reg;
    logic                  s1_rs_reg;
    logic                  s1_rd_reg;
    logic                  s1_sev_reg;

    logic                  fwd_valid_reg;
    logic [IDX_W-1:0]      fwd_idx_reg;
    moesi_pkg::line_entry_t fwd_entry_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    moesi_pkg::line_entry_t cur_entry;
    moesi_pkg::line_entry_t new_entry;
    moesi_pkg::line_state_t cur;
    moesi_pkg::line_state_t snp_view;
    logic [1:0]            op_eff;
    logic                  txn_start;

    logic                  done_reg;
    logic [3:0]            new_state_next, new_state_reg;
    logic [2:0]            cc_command_next, cc_command_reg;
    logic [1:0]            l1_response_next, l1_response_reg;
    logic [1:0]            l1_target_next, l1_target_reg;
    logic                  snoop_resp_valid_next, snoop_resp_valid_reg;
    logic [3:0]            snoop_resp_flags_next, snoop_resp_flags_reg;
    logic [2:0]            l1_broadcast_next, l1_broadcast_reg;
    logic [1:0]            transaction_next, transaction_reg;
    logic                  remove_line_next, remove_line_reg;
    logic [1:0]            status_next, status_reg;
    logic [47:0]           out_addr_next, out_addr_reg;

    assign busy   = clear_reg;
    assign accept = start & ~busy;

    // line slot modulo LINES by shifted compare and subtract
    always_comb
    begin
        slot_rem = line_index;
        for (int k = 9; k >= 0; k--)
        begin
            if ((LINES << k) <= 1023)
            begin
                if (slot_rem >= 10'(LINES << k))
                begin
                    slot_rem = slot_rem - 10'(LINES << k);
                end
            end
        end
    end

    assign idx_in = IDX_W'(slot_rem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_LINE)
                begin
                    clear_reg <= 1'b0;
                end
            end
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg;
            done_reg      <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind;
            s1_idx_reg  <= idx_in;
            s1_addr_reg <= line_addr & ADDR_MASK;
            s1_req_reg  <= requester;
            s1_op_reg   <= l1_opcode;
            s1_snp_reg  <= snoop_opcode;
            s1_rs_reg   <= resp_shared;
            s1_rd_reg   <= resp_dirty;
            s1_sev_reg  <= evicted;
        end
        if (s1_valid_reg)
        begin
            fwd_idx_reg          <= s1_idx_reg;
            fwd_entry_reg        <= new_entry;
            new_state_reg        <= new_state_next;
            cc_command_reg       <= cc_command_next;
            l1_response_reg      <= l1_response_next;
            l1_target_reg        <= l1_target_next;
            snoop_resp_valid_reg <= snoop_resp_valid_next;
            snoop_resp_flags_reg <= snoop_resp_flags_next;
            l1_broadcast_reg     <= l1_broadcast_next;
            transaction_reg      <= transaction_next;
            remove_line_reg      <= remove_line_next;
            status_reg           <= status_next;
            out_addr_reg         <= out_addr_next;
        end
    end

    moesi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (idx_in),
        .rdata (ram_rdata)
    );

    assign ram_we    = clear_reg | s1_valid_reg;
    assign ram_waddr = clear_reg ? clr_cnt_reg : s1_idx_reg;
    assign ram_wdata = clear_reg ? '0 : ENTRY_W'(new_entry);

    // previous event's write lands at the same edge as this read
    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg))
        begin
            cur_entry = fwd_entry_reg;
        end
        else
        begin
            cur_entry = moesi_pkg::line_entry_t'(ram_rdata);
        end
    end

    assign cur      = cur_entry.state;
    assign op_eff   = (s1_op_reg == moesi_pkg::OP_RSVD) ? moesi_pkg::OP_PUT : s1_op_reg;
    assign snp_view = s1_sev_reg ? moesi_pkg::ST_I : cur;

    always_comb
    begin
        new_state_next        = cur;
        cc_command_next       = moesi_pkg::CMD_NONE;
        l1_response_next      = moesi_pkg::RSP_NONE;
        l1_target_next        = 2'd0;
        snoop_resp_valid_next = 1'b0;
        snoop_resp_flags_next = moesi_pkg::SF_NONE;
        l1_broadcast_next     = moesi_pkg::BC_NONE;
        transaction_next      = moesi_pkg::TR_NONE;
        remove_line_next      = 1'b0;
        status_next           = moesi_pkg::STAT_CONSUMED;
        txn_start             = 1'b0;

        unique case (s1_kind_reg)
            moesi_pkg::KIND_L1_REQ:
            begin
                unique case (cur)
                    moesi_pkg::ST_I:
                    begin
                        if (op_eff == moesi_pkg::OP_GETS)
                        begin
                            cc_command_next = moesi_pkg::CMD_READ_SHARED;
                            new_state_next  = moesi_pkg::ST_IS;
                            txn_start       = 1'b1;
                        end
                        else if (op_eff == moesi_pkg::OP_GETE)
                        begin
                            cc_command_next = moesi_pkg::CMD_READ_UNIQUE;
                            new_state_next  = moesi_pkg::ST_IE;
                            txn_start       = 1'b1;
                        end
                    end
                    moesi_pkg::ST_S:
                    begin
                        l1_response_next = moesi_pkg::RSP_NOT_SHARED;
                        if (op_eff == moesi_pkg::OP_GETE)
                        begin
                            l1_broadcast_next = moesi_pkg::BC_INVAL_OTHERS;
                            new_state_next    = moesi_pkg::ST_E;
                        end
                    end
                    moesi_pkg::ST_O:
                    begin
                        if (op_eff == moesi_pkg::OP_GETE)
                        begin
                            cc_command_next = moesi_pkg::CMD_CLEAN_UNIQUE;
                            new_state_next  = moesi_pkg::ST_OE;
                            txn_start       = 1'b1;
                        end
                        else
                        begin
                            status_next = moesi_pkg::STAT_IGNORED;
                        end
                    end
                    moesi_pkg::ST_E:
                    begin
                        if (op_eff == moesi_pkg::OP_GETS)
                        begin
                            l1_broadcast_next = moesi_pkg::BC_SHARE_OTHERS;
                            l1_response_next  = moesi_pkg::RSP_SHARED;
                            new_state_next    = moesi_pkg::ST_S;
                        end
                        else if (op_eff == moesi_pkg::OP_GETE)
                        begin
                            l1_broadcast_next = moesi_pkg::BC_INVAL_OTHERS;
                            l1_response_next  = moesi_pkg::RSP_NOT_SHARED;
                        end
                        else
                        begin
                            cc_command_next = moesi_pkg::CMD_EVICT;
                            new_state_next  = moesi_pkg::ST_EI;
                            txn_start       = 1'b1;
                        end
                    end
                    moesi_pkg::ST_M:
                    begin
                        if (op_eff == moesi_pkg::OP_GETS)
                        begin
                            l1_response_next = moesi_pkg::RSP_SHARED;
                            new_state_next   = moesi_pkg::ST_O;
                        end
                        else if (op_eff == moesi_pkg::OP_GETE)
                        begin
                            l1_broadcast_next = moesi_pkg::BC_INVAL_OTHERS;
                            l1_response_next  = moesi_pkg::RSP_NOT_SHARED;
                        end
                        else
                        begin
                            cc_command_next = moesi_pkg::CMD_WRITE_BACK;
                            new_state_next  = moesi_pkg::ST_MI;
                            txn_start       = 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = moesi_pkg::STAT_IGNORED;
                    end
                endcase
                if (txn_start)
                begin
                    transaction_next = moesi_pkg::TR_START;
                end
                if (l1_response_next != moesi_pkg::RSP_NONE)
                begin
                    l1_target_next = s1_req_reg;
                end
            end
            moesi_pkg::KIND_CC_RESP:
            begin
                unique case (cur)
                    moesi_pkg::ST_IS:
                    begin
                        if (s1_rs_reg && s1_rd_reg)
                        begin
                            l1_response_next = moesi_pkg::RSP_NOT_SHARED;
                            new_state_next   = moesi_pkg::ST_O;
                        end
                        else if (!s1_rs_reg && !s1_rd_reg)
                        begin
                            l1_response_next = moesi_pkg::RSP_NOT_SHARED;
                            new_state_next   = moesi_pkg::ST_E;
                        end
                        else
                        begin
                            l1_response_next = moesi_pkg::RSP_SHARED;
                            new_state_next   = moesi_pkg::ST_S;
                        end
                        transaction_next = moesi_pkg::TR_END;
                    end
                    moesi_pkg::ST_IE:
                    begin
                        l1_response_next = moesi_pkg::RSP_NOT_SHARED;
                        new_state_next   = s1_rd_reg ? moesi_pkg::ST_O : moesi_pkg::ST_E;
                        transaction_next = moesi_pkg::TR_END;
                    end
                    moesi_pkg::ST_OE:
                    begin
                        l1_response_next = moesi_pkg::RSP_NOT_SHARED;
                        new_state_next   = moesi_pkg::ST_E;
                        transaction_next = moesi_pkg::TR_END;
                    end
                    moesi_pkg::ST_EI, moesi_pkg::ST_MI:
                    begin
                        if (cur_entry.opcode == moesi_pkg::OP_PUT)
                        begin
                            l1_response_next = moesi_pkg::RSP_NOT_SHARED;
                            new_state_next   = moesi_pkg::ST_I;
                            remove_line_next = 1'b1;
                            transaction_next = moesi_pkg::TR_END;
                        end
                        else
                        begin
                            status_next = moesi_pkg::STAT_IGNORED;
                        end
                    end
                    default:
                    begin
                        status_next = moesi_pkg::STAT_IGNORED;
                    end
                endcase
                if (l1_response_next != moesi_pkg::RSP_NONE)
                begin
                    l1_target_next = cur_entry.requester;
                end
            end
            moesi_pkg::KIND_SNOOP:
            begin
                if (s1_snp_reg == moesi_pkg::SNP_READ_SHARED)
                begin
                    snoop_resp_valid_next = 1'b1;
                    if (snp_view == moesi_pkg::ST_E)
                    begin
                        snoop_resp_flags_next = moesi_pkg::SF_SHARED_FWD;
                        new_state_next        = moesi_pkg::ST_S;
                        l1_broadcast_next     = moesi_pkg::BC_SHARE_ALL;
                    end
                    else if (snp_view == moesi_pkg::ST_S)
                    begin
                        snoop_resp_flags_next = moesi_pkg::SF_SHARED;
                    end
                    else if (snp_view == moesi_pkg::ST_M)
                    begin
                        snoop_resp_flags_next = moesi_pkg::SF_SHARED_FWD;
                        new_state_next        = moesi_pkg::ST_O;
                        l1_broadcast_next     = moesi_pkg::BC_SHARE_ALL;
                    end
                end
                else if (s1_snp_reg == moesi_pkg::SNP_READ_UNIQUE ||
                         s1_snp_reg == moesi_pkg::SNP_MAKE_INVALID ||
                         s1_snp_reg == moesi_pkg::SNP_CLEAN_INVAL)
                begin
                    snoop_resp_valid_next = 1'b1;
                    if (s1_snp_reg == moesi_pkg::SNP_READ_UNIQUE)
                    begin
                        if (cur == moesi_pkg::ST_I || cur == moesi_pkg::ST_S ||
                            cur == moesi_pkg::ST_E)
                        begin
                            snoop_resp_flags_next = moesi_pkg::SF_UNIQUE;
                        end
                        else if (cur == moesi_pkg::ST_O || cur == moesi_pkg::ST_M)
                        begin
                            snoop_resp_flags_next = moesi_pkg::SF_UNIQUE_DRT;
                        end
                    end
                    else if (s1_snp_reg == moesi_pkg::SNP_CLEAN_INVAL &&
                             (cur == moesi_pkg::ST_O || cur == moesi_pkg::ST_M))
                    begin
                        snoop_resp_flags_next = moesi_pkg::SF_CLEAN_DRT;
                    end
                    new_state_next    = moesi_pkg::ST_I;
                    remove_line_next  = 1'b1;
                    l1_broadcast_next = moesi_pkg::BC_INVAL_ALL;
                end
                else
                begin
                    status_next = moesi_pkg::STAT_FATAL;
                end
            end
            default:
            begin
                if (cur == moesi_pkg::ST_E || cur == moesi_pkg::ST_O || cur == moesi_pkg::ST_M)
                begin
                    new_state_next = moesi_pkg::ST_M;
                end
                else
                begin
                    status_next = moesi_pkg::STAT_FATAL;
                end
            end
        endcase

        if (cc_command_next != moesi_pkg::CMD_NONE || l1_broadcast_next != moesi_pkg::BC_NONE)
        begin
            out_addr_next = s1_addr_reg;
        end
        else
        begin
            out_addr_next = '0;
        end
    end

    always_comb
    begin
        new_entry       = cur_entry;
        new_entry.state = moesi_pkg::line_state_t'(new_state_next);
        if (txn_start)
        begin
            new_entry.opcode    = op_eff;
            new_entry.requester = s1_req_reg;
        end
    end

    assign done             = done_reg;
    assign new_state        = new_state_reg;
    assign cc_command       = cc_command_reg;
    assign l1_response      = l1_response_reg;
    assign l1_target        = l1_target_reg;
    assign snoop_resp_valid = snoop_resp_valid_reg;
    assign snoop_resp_flags = snoop_resp_flags_reg;
    assign l1_broadcast     = l1_broadcast_reg;
    assign transaction      = transaction_reg;
    assign remove_line      = remove_line_reg;
    assign status           = status_reg;
    assign out_addr         = out_addr_reg;

    // no event in flight while lines are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s1_valid_reg && !done_reg)
        else $error("event in flight during line clear");

    // clearing ends only after the last line was written
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_reg) |-> $past(clr_cnt_reg) == LAST_LINE)
        else $error("line clear ended early");

    // an ignored event has no side effects
    assert property (@(posedge clk) disable iff (!rst_n)
        done && status == moesi_pkg::STAT_IGNORED |->
            cc_command == moesi_pkg::CMD_NONE && l1_response == moesi_pkg::RSP_NONE &&
            transaction == moesi_pkg::TR_NONE && !remove_line && !snoop_resp_valid)
        else $error("ignored event produced actions");

    // flags only with a snoop response, target only with an l1 response
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (snoop_resp_valid || snoop_resp_flags == moesi_pkg::SF_NONE) &&
                 (l1_response != moesi_pkg::RSP_NONE || l1_target == 2'd0))
        else $error("stray response fields");

    // line removal always ends in invalid
    assert property (@(posedge clk) disable iff (!rst_n)
        done && remove_line |-> new_state == moesi_pkg::ST_I)
        else $error("removed line not invalid");

endmodule

// File: tb/moesi_line_checker.sv
module moesi_line_checker
    import moesi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [9:0]  line_index,
    input  logic [47:0] line_addr,
    input  logic [1:0]  requester,
    input  logic [1:0]  l1_opcode,
    input  logic [2:0]  snoop_opcode,
    input  logic        resp_shared,
    input  logic        resp_dirty,
    input  logic        evicted,
    input  logic        done,
    input  logic [3:0]  new_state,
    input  logic [2:0]  cc_command,
    input  logic [1:0]  l1_response,
    input  logic [1:0]  l1_target,
    input  logic        snoop_resp_valid,
    input  logic [3:0]  snoop_resp_flags,
    input  logic [2:0]  l1_broadcast,
    input  logic [1:0]  transaction,
    input  logic        remove_line,
    input  logic [1:0]  status,
    input  logic [47:0] out_addr,
    output int          fail_count,
    output int          results_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_LINES = 1024;

    typedef struct packed {
        line_state_t nstate;
        logic [2:0]  cmd;
        logic [1:0]  rsp;
        logic [1:0]  tgt;
        logic        snp_valid;
        logic [3:0]  snp_flags;
        logic [2:0]  bcast;
        logic [1:0]  trans;
        logic        remove;
        logic [1:0]  stat;
        logic [47:0] addr;
    } coh_result_t;

    line_state_t line_tab [N_LINES];
    logic [1:0]  pend_op  [N_LINES];
    logic [1:0]  pend_req [N_LINES];

    coh_result_t awaited_results [$];
    coh_result_t got_result;
    coh_result_t want_result;
    coh_result_t predicted;

    function automatic string fmt_result(coh_result_t r);
        return $sformatf({"st=%0d cmd=%0d rsp=%0d tgt=%0d sv=%0b sf=%h bc=%0d tr=%0d",
                          " rm=%0b stat=%0d addr=%h"},
                         r.nstate, r.cmd, r.rsp, r.tgt, r.snp_valid, r.snp_flags,
                         r.bcast, r.trans, r.remove, r.stat, r.addr);
    endfunction

    function automatic coh_result_t predict_event(
        input logic [1:0]  k,
        input logic [9:0]  idx,
        input logic [47:0] addr,
        input logic [1:0]  req,
        input logic [1:0]  op_in,
        input logic [2:0]  snp,
        input logic        rs,
        input logic        rd,
        input logic        sev
    );
        coh_result_t r;
        line_state_t cur;
        line_state_t seen;
        logic [1:0]  op;
        logic        opens;
        cur = line_tab[idx];
        r = '0;
        r.nstate = cur;
        op = (op_in == OP_RSVD) ? OP_PUT : op_in;
        opens = 1'b0;
        case (k)
            KIND_L1_REQ:
            begin
                case (cur)
                    ST_I:
                    begin
                        if (op == OP_GETS)
                        begin
                            r.cmd = CMD_READ_SHARED;
                            r.nstate = ST_IS;
                            opens = 1'b1;
                        end
                        else if (op == OP_GETE)
                        begin
                            r.cmd = CMD_READ_UNIQUE;
                            r.nstate = ST_IE;
                            opens = 1'b1;
                        end
                    end
                    ST_S:
                    begin
                        r.rsp = RSP_NOT_SHARED;
                        if (op == OP_GETE)
                        begin
                            r.bcast = BC_INVAL_OTHERS;
                            r.nstate = ST_E;
                        end
                    end
                    ST_O:
                    begin
                        if (op == OP_GETE)
                        begin
                            r.cmd = CMD_CLEAN_UNIQUE;
                            r.nstate = ST_OE;
                            opens = 1'b1;
                        end
                        else
                            r.stat = STAT_IGNORED;
                    end
                    ST_E:
                    begin
                        if (op == OP_GETS)
                        begin
                            r.bcast = BC_SHARE_OTHERS;
                            r.rsp = RSP_SHARED;
                            r.nstate = ST_S;
                        end
                        else if (op == OP_GETE)
                        begin
                            r.bcast = BC_INVAL_OTHERS;
                            r.rsp = RSP_NOT_SHARED;
                        end
                        else
                        begin
                            r.cmd = CMD_EVICT;
                            r.nstate = ST_EI;
                            opens = 1'b1;
                        end
                    end
                    ST_M:
                    begin
                        if (op == OP_GETS)
                        begin
                            r.rsp = RSP_SHARED;
                            r.nstate = ST_O;
                        end
                        else if (op == OP_GETE)
                        begin
                            r.bcast = BC_INVAL_OTHERS;
                            r.rsp = RSP_NOT_SHARED;
                        end
                        else
                        begin
                            r.cmd = CMD_WRITE_BACK;
                            r.nstate = ST_MI;
                            opens = 1'b1;
                        end
                    end
                    default:
                        r.stat = STAT_IGNORED;
                endcase
                if (opens)
                begin
                    r.trans = TR_START;
                    pend_op[idx] = op;
                    pend_req[idx] = req;
                end
                if (r.rsp != RSP_NONE)
                    r.tgt = req;
            end
            KIND_CC_RESP:
            begin
                case (cur)
                    ST_IS:
                    begin
                        if (rs && rd)
                        begin
                            r.rsp = RSP_NOT_SHARED;
                            r.nstate = ST_O;
                        end
                        else if (!rs && !rd)
                        begin
                            r.rsp = RSP_NOT_SHARED;
                            r.nstate = ST_E;
                        end
                        else
                        begin
                            r.rsp = RSP_SHARED;
                            r.nstate = ST_S;
                        end
                        r.trans = TR_END;
                    end
                    ST_IE:
                    begin
                        r.rsp = RSP_NOT_SHARED;
                        r.nstate = rd ? ST_O : ST_E;
                        r.trans = TR_END;
                    end
                    ST_OE:
                    begin
                        r.rsp = RSP_NOT_SHARED;
                        r.nstate = ST_E;
                        r.trans = TR_END;
                    end
                    ST_EI, ST_MI:
                    begin
                        if (pend_op[idx] == OP_PUT)
                        begin
                            r.rsp = RSP_NOT_SHARED;
                            r.nstate = ST_I;
                            r.remove = 1'b1;
                            r.trans = TR_END;
                        end
                        else
                            r.stat = STAT_IGNORED;
                    end
                    default:
                        r.stat = STAT_IGNORED;
                endcase
                if (r.rsp != RSP_NONE)
                    r.tgt = pend_req[idx];
            end
            KIND_SNOOP:
            begin
                if (snp == SNP_READ_SHARED)
                begin
                    seen = sev ? ST_I : cur;
                    r.snp_valid = 1'b1;
                    if (seen == ST_E)
                    begin
                        r.snp_flags = SF_SHARED_FWD;
                        r.nstate = ST_S;
                        r.bcast = BC_SHARE_ALL;
                    end
                    else if (seen == ST_S)
                        r.snp_flags = SF_SHARED;
                    else if (seen == ST_M)
                    begin
                        r.snp_flags = SF_SHARED_FWD;
                        r.nstate = ST_O;
                        r.bcast = BC_SHARE_ALL;
                    end
                end
                else if (snp <= SNP_CLEAN_INVAL)
                begin
                    r.snp_valid = 1'b1;
                    if (snp == SNP_READ_UNIQUE)
                    begin
                        if (cur == ST_I || cur == ST_S || cur == ST_E)
                            r.snp_flags = SF_UNIQUE;
                        else if (cur == ST_O || cur == ST_M)
                            r.snp_flags = SF_UNIQUE_DRT;
                    end
                    else if (snp == SNP_CLEAN_INVAL && (cur == ST_O || cur == ST_M))
                        r.snp_flags = SF_CLEAN_DRT;
                    r.nstate = ST_I;
                    r.remove = 1'b1;
                    r.bcast = BC_INVAL_ALL;
                end
                else
                    r.stat = STAT_FATAL;
            end
            default:
            begin
                if (cur == ST_E || cur == ST_O || cur == ST_M)
                    r.nstate = ST_M;
                else
                    r.stat = STAT_FATAL;
            end
        endcase
        line_tab[idx] = r.nstate;
        r.addr = (r.cmd != CMD_NONE || r.bcast != BC_NONE) ? addr : 48'd0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_LINES; i++)
            begin
                line_tab[i] = ST_I;
                pend_op[i] = OP_GETS;
                pend_req[i] = 2'd0;
            end
            awaited_results.delete();
            results_owed = 0;
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                got_result = coh_result_t'({new_state, cc_command, l1_response, l1_target,
                                            snoop_resp_valid, snoop_resp_flags, l1_broadcast,
                                            transaction, remove_line, status, out_addr});
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing outstanding: %s", fmt_result(got_result));
                end
                else
                begin
                    want_result = awaited_results.pop_front();
                    if (got_result !== want_result)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", fmt_result(want_result));
                            $display("  actual   %s", fmt_result(got_result));
                        end
                    end
                end
            end
            // accepted transfer
            if (start && !busy)
            begin
                predicted = predict_event(kind, line_index, line_addr, requester,
                                          l1_opcode, snoop_opcode, resp_shared,
                                          resp_dirty, evicted);
                awaited_results = {awaited_results, predicted};
            end
            results_owed = awaited_results.size();
        end
    end

endmodule

// File: tb/tb.sv
module tb;

    import moesi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_EVENTS = 1700;
    localparam int          LIMIT_CYCLES  = 200000;
    localparam logic [2:0]  SNP_UNKNOWN   = 3'd4;
    localparam logic [47:0] A1            = '1;
    localparam logic [47:0] A0            = '0;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [9:0]  line_index;
    logic [47:0] line_addr;
    logic [1:0]  requester;
    logic [1:0]  l1_opcode;
    logic [2:0]  snoop_opcode;
    logic        resp_shared;
    logic        resp_dirty;
    logic        evicted;
    logic        done;
    logic [3:0]  new_state;
    logic [2:0]  cc_command;
    logic [1:0]  l1_response;
    logic [1:0]  l1_target;
    logic        snoop_resp_valid;
    logic [3:0]  snoop_resp_flags;
    logic [2:0]  l1_broadcast;
    logic [1:0]  transaction;
    logic        remove_line;
    logic [1:0]  status;
    logic [47:0] out_addr;
    int          fail_count;
    int          results_owed;
    int          cycle_count;
    logic [9:0]  hot_lines [16];

    moesi_l2_line_coherence_unit DUT (.*);

    moesi_line_checker coherence_check (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic issue(
        input logic [1:0]  k,
        input logic [9:0]  idx,
        input logic [47:0] a,
        input logic [1:0]  rq,
        input logic [1:0]  op,
        input logic [2:0]  sn,
        input logic        rs,
        input logic        rd,
        input logic        sev
    );
        @(negedge clk);
        kind <= k;
        line_index <= idx;
        line_addr <= a;
        requester <= rq;
        l1_opcode <= op;
        snoop_opcode <= sn;
        resp_shared <= rs;
        resp_dirty <= rd;
        evicted <= sev;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    initial
    begin
        logic [1:0]  rk;
        logic [9:0]  ridx;
        logic [2:0]  rsnp;
        int          pick;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_L1_REQ;
        line_index = '0;
        line_addr = '0;
        requester = '0;
        l1_opcode = OP_GETS;
        snoop_opcode = SNP_READ_SHARED;
        resp_shared = 1'b0;
        resp_dirty = 1'b0;
        evicted = 1'b0;
        hot_lines[0] = 10'd0;
        hot_lines[1] = 10'd1023;
        for (int i = 2; i < 16; i++)
            hot_lines[i] = 10'($urandom_range(1023));
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(KIND_L1_REQ,  10'd0,    A1, 2'd0, OP_PUT,  SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_SET_MOD, 10'd0,    A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_CC_RESP, 10'd0,    A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b1, 1'b1, 1'b0);
        issue(KIND_SNOOP,   10'd0,    A1, 2'd0, OP_GETS, SNP_UNKNOWN,      1'b0, 1'b0, 1'b0);
        issue(KIND_SNOOP,   10'd0,    A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1,    A1, 2'd1, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1,    A0, 2'd2, OP_GETE, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_CC_RESP, 10'd1,    A0, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b1, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1,    A1, 2'd3, OP_PUT,  SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1,    A1, 2'd0, OP_RSVD, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1,    A1, 2'd2, OP_GETE, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1,    A0, 2'd1, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_SNOOP,   10'd1,    A1, 2'd0, OP_GETS, SNP_READ_UNIQUE,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1023, A1, 2'd3, OP_GETE, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_CC_RESP, 10'd1023, A0, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b1, 1'b0);
        issue(KIND_L1_REQ,  10'd1023, A1, 2'd1, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_SNOOP,   10'd1023, A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b1);
        issue(KIND_SET_MOD, 10'd1023, A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1023, A1, 2'd2, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_L1_REQ,  10'd1023, A1, 2'd0, OP_GETE, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_CC_RESP, 10'd1023, A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b1, 1'b0, 1'b0);
        issue(KIND_SET_MOD, 10'd1023, A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_SNOOP,   10'd1023, A1, 2'd0, OP_GETS, SNP_READ_SHARED,  1'b0, 1'b0, 1'b0);
        issue(KIND_SNOOP,   10'd1023, A1, 2'd0, OP_GETS, SNP_CLEAN_INVAL,  1'b0, 1'b0, 1'b0);
        issue(KIND_SNOOP,   10'd0,    A0, 2'd0, OP_GETS, SNP_MAKE_INVALID, 1'b0, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_EVENTS; n++)
        begin
            // every 400th event, drain everything outstanding before the next transfer
            if (n % 400 == 399)
            begin
                hold_off(1);
                wait (results_owed == 0);
            end
            else if (n < 600 || n >= 900)
            begin
                while ($urandom_range(99) < 37)
                    hold_off(1);
            end
            pick = $urandom_range(99);
            if (pick < 45)
                rk = KIND_L1_REQ;
            else if (pick < 75)
                rk = KIND_CC_RESP;
            else if (pick < 90)
                rk = KIND_SNOOP;
            else
                rk = KIND_SET_MOD;
            pick = $urandom_range(99);
            if (pick < 50)
                rsnp = SNP_READ_SHARED;
            else if (pick < 88)
                rsnp = 3'($urandom_range(3, 1));
            else
                rsnp = 3'($urandom_range(7, 4));
            if ($urandom_range(99) < 80)
                ridx = hot_lines[4'($urandom_range(15))];
            else
                ridx = 10'($urandom_range(1023));
            issue(rk, ridx, 48'({$urandom(), $urandom()}), 2'($urandom_range(3)),
                  2'($urandom_range(3)), rsnp, 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(99) < 20));
        end

        hold_off(1);
        wait (results_owed == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
